// File: design/mma_pkg.sv
// Shared types, constants and helper functions for the multichannel moving average.
// Used by every module in the design folder except mma_ram; depends on nothing else.
package mma_pkg;

  localparam int CH_W = 20;
  localparam int NUM_CH = 10;
  localparam int FILL_W = 3;
  localparam int WINDOW_DEPTH_DEF = 6;
  // Quotient bits resolved per cycle by each lane's divider.
  localparam int DIV_BITS = 3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic            command;
    logic            warmed_up;
    logic [CH_W-1:0] pm1_mass;
    logic [CH_W-1:0] pm25_mass;
    logic [CH_W-1:0] pm4_mass;
    logic [CH_W-1:0] pm10_mass;
    logic [CH_W-1:0] count_05;
    logic [CH_W-1:0] count_10;
    logic [CH_W-1:0] count_25;
    logic [CH_W-1:0] count_40;
    logic [CH_W-1:0] count_100;
    logic [CH_W-1:0] typical_size;
  } in_t;

  typedef struct packed {
    logic              valid_res;
    logic [FILL_W-1:0] fill;
    logic [CH_W-1:0]   avg_pm1;
    logic [CH_W-1:0]   avg_pm25;
    logic [CH_W-1:0]   avg_pm4;
    logic [CH_W-1:0]   avg_pm10;
    logic [CH_W-1:0]   avg_c05;
    logic [CH_W-1:0]   avg_c10;
    logic [CH_W-1:0]   avg_c25;
    logic [CH_W-1:0]   avg_c40;
    logic [CH_W-1:0]   avg_c100;
    logic [CH_W-1:0]   avg_size;
  } out_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] chan_vec_t;

  // Control shared by all lanes, driven from the sequencer in the top level.
  typedef struct packed {
    logic load;      // latch the sample and read the slot it replaces
    logic update;    // fold the sample into the running sum and write it back
    logic full;      // the slot being written holds a sample still in the window
    logic empty;     // the window holds no sample, so the old sum is void
    logic div_step;  // advance the divider by one group of quotient bits
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_PUSH
  } state_t;

  function automatic chan_vec_t split_channels(in_t d);
    chan_vec_t v;
    v[0] = d.pm1_mass;
    v[1] = d.pm25_mass;
    v[2] = d.pm4_mass;
    v[3] = d.pm10_mass;
    v[4] = d.count_05;
    v[5] = d.count_10;
    v[6] = d.count_25;
    v[7] = d.count_40;
    v[8] = d.count_100;
    v[9] = d.typical_size;
    return v;
  endfunction

  function automatic out_t merge_channels(logic valid, logic [FILL_W-1:0] fill,
                                          chan_vec_t v);
    out_t r;
    r.valid_res = valid;
    r.fill      = fill;
    r.avg_pm1   = v[0];
    r.avg_pm25  = v[1];
    r.avg_pm4   = v[2];
    r.avg_pm10  = v[3];
    r.avg_c05   = v[4];
    r.avg_c10   = v[5];
    r.avg_c25   = v[6];
    r.avg_c40   = v[7];
    r.avg_c100  = v[8];
    r.avg_size  = v[9];
    return r;
  endfunction

endpackage

// File: design/multichannel_moving_average.sv
// Top level of the ten-channel moving average: sequencer, window bookkeeping,
// one lane per channel and the merging output register. Depends on mma_pkg, mma_lane.
//
//   channel  signals                          payload
//   in       in_valid, in_stall, in_data      mma_pkg::in_t  (command, flag, ten readings)
//   out      out_valid, out_stall, out_data   mma_pkg::out_t (flag, fill, ten means)
//
// A sample passes through the update, divide and push states; the divide state runs
// the lanes' radix-8 dividers.
// A clear command goes straight to the push state; a sample that is not warmed up is dropped.
// Reset empties the window; the history memory itself is never cleared.
// A finished result sits in the output register, so the next item is taken while
// it waits; a new result waits in the sequencer only while that register is held.
module multichannel_moving_average #(
  parameter int WINDOW_DEPTH = mma_pkg::WINDOW_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mma_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mma_pkg::out_t out_data
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = mma_pkg::CH_W + $clog2(WINDOW_DEPTH);
  localparam int DIV_STEPS = (SUM_W + mma_pkg::DIV_BITS - 1) / mma_pkg::DIV_BITS;
  localparam int STEP_W = $clog2(DIV_STEPS);

  mma_pkg::state_t     state_r, state_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                res_valid_r, res_valid_nxt;
  logic                out_valid_r;
  mma_pkg::out_t       out_data_r;
  mma_pkg::out_t       result;
  mma_pkg::lane_ctrl_t ctrl;
  mma_pkg::chan_vec_t  samples;
  mma_pkg::chan_vec_t  quotients;
  logic                in_accept;
  logic                is_clear;
  logic                is_sample;
  logic                push;
  logic                last_step;
  logic [CNT_W+2:0]    fill_ext;

  assign in_stall  = (state_r != mma_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_clear  = (in_data.command == mma_pkg::CMD_CLEAR);
  assign is_sample = (in_data.command == mma_pkg::CMD_SAMPLE) && in_data.warmed_up;
  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));
  assign push      = (state_r == mma_pkg::ST_PUSH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mma_pkg::ST_IDLE: begin
        if (in_accept && is_clear) begin
          state_nxt = mma_pkg::ST_PUSH;
        end else if (in_accept && is_sample) begin
          state_nxt = mma_pkg::ST_UPD;
        end
      end
      mma_pkg::ST_UPD: state_nxt = mma_pkg::ST_DIV;
      mma_pkg::ST_DIV: begin
        if (last_step) begin
          state_nxt = mma_pkg::ST_PUSH;
        end
      end
      mma_pkg::ST_PUSH: begin
        if (push) begin
          state_nxt = mma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    step_nxt      = step_r;
    res_valid_nxt = res_valid_r;
    unique case (state_r)
      mma_pkg::ST_IDLE: begin
        if (in_accept && is_clear) begin
          slot_nxt      = '0;
          fill_nxt      = '0;
          res_valid_nxt = 1'b0;
        end else if (in_accept && is_sample) begin
          ctrl.load     = 1'b1;
          res_valid_nxt = 1'b1;
        end
      end
      mma_pkg::ST_UPD: begin
        ctrl.update = 1'b1;
        ctrl.full   = (fill_r == CNT_W'(WINDOW_DEPTH));
        ctrl.empty  = (fill_r == '0);
        slot_nxt    = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (fill_r != CNT_W'(WINDOW_DEPTH)) begin
          fill_nxt = fill_r + 1'b1;
        end
        step_nxt = '0;
      end
      mma_pkg::ST_DIV: begin
        ctrl.div_step = 1'b1;
        step_nxt      = step_r + 1'b1;
      end
      mma_pkg::ST_PUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mma_pkg::ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      step_r      <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      step_r      <= step_nxt;
      res_valid_r <= res_valid_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign samples = mma_pkg::split_channels(in_data);

  for (genvar j = 0; j < mma_pkg::NUM_CH; j++) begin : g_lane
    mma_lane #(
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .SLOT_W      (SLOT_W),
      .CNT_W       (CNT_W)
    ) u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .slot    (slot_r),
      .divisor (fill_r),
      .sample  (samples[j]),
      .quotient(quotients[j])
    );
  end

  // The fill field carries only the low bits of the count for deep windows.
  assign fill_ext = {3'b000, fill_r};

  always_comb begin
    if (res_valid_r) begin
      result = mma_pkg::merge_channels(1'b1, fill_ext[2:0], quotients);
    end else begin
      result = mma_pkg::merge_channels(1'b0, '0, '0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/mma_ram.sv
// Generic single-port RAM with a registered read.
// Standalone; used by each averaging lane for its window history.
module mma_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 6,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/mma_lane.sv
// One averaging lane: window history, running sum and an iterative divider.
// Depends on mma_pkg and mma_ram.
module mma_lane #(
  parameter int WINDOW_DEPTH = mma_pkg::WINDOW_DEPTH_DEF,
  parameter int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  parameter int CNT_W = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                    clk,
  input  mma_pkg::lane_ctrl_t     ctrl,
  input  logic [SLOT_W-1:0]       slot,
  input  logic [CNT_W-1:0]        divisor,
  input  logic [mma_pkg::CH_W-1:0] sample,
  output logic [mma_pkg::CH_W-1:0] quotient
);

  localparam int SUM_W = mma_pkg::CH_W + $clog2(WINDOW_DEPTH);
  localparam int DIV_STEPS = (SUM_W + mma_pkg::DIV_BITS - 1) / mma_pkg::DIV_BITS;
  localparam int DVD_W = DIV_STEPS * mma_pkg::DIV_BITS;
  localparam int REM_W = CNT_W + 1;

  logic [mma_pkg::CH_W-1:0] sample_r;
  logic [mma_pkg::CH_W-1:0] old_val;
  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W-1:0]         sum_nxt;
  logic [DVD_W-1:0]         dvd_r;
  logic [DVD_W-1:0]         dvd_nxt;
  logic [REM_W-1:0]         rem_r;
  logic [REM_W-1:0]         rem_nxt;

  mma_ram #(
    .WIDTH (mma_pkg::CH_W),
    .DEPTH (WINDOW_DEPTH),
    .ADDR_W(SLOT_W)
  ) u_hist (
    .clk  (clk),
    .we   (ctrl.update),
    .addr (slot),
    .wdata(sample_r),
    .rdata(old_val)
  );

  // The slot read at load time drops out of the window once it is full.
  always_comb begin
    sum_nxt = (ctrl.empty ? SUM_W'(0) : sum_r)
            - (ctrl.full ? SUM_W'(old_val) : SUM_W'(0))
            + SUM_W'(sample_r);
  end

  // Restoring division, several quotient bits per cycle, shifted in from the right.
  always_comb begin
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
    rem = rem_r;
    dvd = dvd_r;
    for (int k = 0; k < mma_pkg::DIV_BITS; k++) begin
      trial = {rem[REM_W-2:0], dvd[DVD_W-1]};
      dvd = {dvd[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem = trial - {1'b0, divisor};
        dvd[0] = 1'b1;
      end else begin
        rem = trial;
      end
    end
    rem_nxt = rem;
    dvd_nxt = dvd;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_r <= sample;
    end
    if (ctrl.update) begin
      sum_r <= sum_nxt;
      dvd_r <= DVD_W'(sum_nxt);
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dvd_r[mma_pkg::CH_W-1:0];

endmodule

// File: design/mma_checker.sv
// Port-level checks for the multichannel moving average, bound to its top level.
// Depends on mma_pkg and the multichannel_moving_average module.
module mma_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input mma_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input mma_pkg::out_t out_data
);

  // A held result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The answer to a clear command carries no averages and an empty window.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |->
      out_data.fill == '0 && out_data.avg_pm1 == '0 && out_data.avg_pm25 == '0 &&
      out_data.avg_pm4 == '0 && out_data.avg_pm10 == '0 && out_data.avg_c05 == '0 &&
      out_data.avg_c10 == '0 && out_data.avg_c25 == '0 && out_data.avg_c40 == '0 &&
      out_data.avg_c100 == '0 && out_data.avg_size == '0)
    else $error("clear answer carries data");

  // Any item that does work occupies the block for at least the next cycle.
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
      (in_data.command == mma_pkg::CMD_CLEAR || in_data.warmed_up) |=> in_stall)
    else $error("block free straight after taking an item");

  // A dropped sample leaves the block ready for the next item.
  a_drop_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == mma_pkg::CMD_SAMPLE &&
      !in_data.warmed_up |=> !in_stall)
    else $error("dropped sample held the block");

  // Nothing is offered straight out of reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
